[rtl/core/hid_pkg.sv]
package hid_pkg;

  localparam int NODE_W   = 64;
  localparam int LEVEL_W  = 6;
  localparam int SLOT_W   = 31;
  localparam int PARENT_W = 58;

  // most decimal digits a well formed ID may have
  localparam int ID_DIGITS = 19;

  // decimal digits needed for any positive 63-bit value
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int MAG_W      = NODE_W - 1;

  localparam int CNT_W    = $clog2(MAG_W + 1);
  localparam int DCNT_W   = $clog2(BCD_DIGITS + 1);
  localparam int GROUP_W  = LEVEL_W - 1;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(BCD_DIGITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_WALK = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

endpackage

[rtl/core/hid_req_if.sv]
interface hid_req_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hid_pkg::NODE_W-1:0]     node_id;

  modport source (output valid, output node_id, input ready);
  modport sink   (input valid, input node_id, output ready);
endinterface

[rtl/core/hid_res_if.sv]
interface hid_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  id_valid;
  logic signed [hid_pkg::LEVEL_W-1:0]    tree_level;
  logic signed [hid_pkg::SLOT_W-1:0]     child_slot;
  logic signed [hid_pkg::PARENT_W-1:0]   parent_code;

  modport source (output valid, output id_valid, output tree_level, output child_slot,
                  output parent_code, input ready);
  modport sink   (input valid, input id_valid, input tree_level, input child_slot,
                  input parent_code, output ready);
endinterface

[rtl/core/hierarchical_id_parse.sv]
// Hierarchical ID decoder. Each word on request gives one word on result: validity, tree
// level, final group value and parent ID of a signed 64-bit ID whose decimal digits form
// groups of a length digit followed by that many digits. A positive ID goes from acceptance
// through bit-serial binary to decimal conversion (one magnitude bit per cycle through a
// shift-and-add-3 digit register), a walk over the decimal digits most significant first,
// and the load of the output register. Zero and negative IDs go straight to the load. One
// ID is decoded at a time; request is ready again as soon as the result is in the output
// register, so the next ID overlaps a result that is still waiting to be taken.
module hierarchical_id_parse (
  input  logic           clk,
  input  logic           rst,
  hid_req_if.sink        request,
  hid_res_if.source      result
);

  hid_pkg::state_t                   state;
  logic [hid_pkg::CNT_W-1:0]         cnt;
  logic [hid_pkg::MAG_W-1:0]         mag;
  logic [hid_pkg::BCD_W-1:0]         bcd;
  logic                              is_root;
  logic                              is_neg;

  logic                              started;
  logic [hid_pkg::DCNT_W-1:0]        ndig;
  logic [3:0]                        rem;
  logic [3:0]                        len;
  logic                              lead0;
  logic [hid_pkg::GROUP_W-1:0]       groups;
  logic [hid_pkg::PARENT_W-1:0]      full;
  logic [hid_pkg::PARENT_W-1:0]      parent;
  logic [hid_pkg::SLOT_W-1:0]        slot;

  logic                              out_vld;
  logic                              out_ok;
  logic [hid_pkg::LEVEL_W-1:0]       out_level;
  logic [hid_pkg::SLOT_W-1:0]        out_slot;
  logic [hid_pkg::PARENT_W-1:0]      out_parent;

  logic [hid_pkg::BCD_W-1:0]         bcd_adj;
  logic [3:0]                        digit;
  logic                              take;
  logic [hid_pkg::PARENT_W-1:0]      full_next;
  logic [hid_pkg::SLOT_W-1:0]        slot_next;
  logic                              walk_ok;
  logic                              out_free;

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < hid_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign digit     = bcd[hid_pkg::BCD_W-1 -: 4];
  assign take      = started || (digit != 4'd0);
  assign full_next = (full << 3) + (full << 1) + hid_pkg::PARENT_W'(digit);
  assign slot_next = (slot << 3) + (slot << 1) + hid_pkg::SLOT_W'(digit);

  assign walk_ok = (rem == 4'd0) && (len != 4'd0) && !((len > 4'd1) && lead0) &&
                   (ndig <= hid_pkg::DCNT_W'(hid_pkg::ID_DIGITS));

  assign out_free = !out_vld || result.ready;

  assign request.ready = (state == hid_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hid_pkg::ST_IDLE;
      cnt     <= '0;
      out_vld <= 1'b0;
    end else begin
      // the load arm refills the output register itself
      if (out_vld && result.ready && (state != hid_pkg::ST_LOAD)) begin
        out_vld <= 1'b0;
      end
      case (state)
        hid_pkg::ST_IDLE: begin
          if (request.valid) begin
            mag     <= request.node_id[hid_pkg::MAG_W-1:0];
            bcd     <= '0;
            is_root <= (request.node_id == '0);
            is_neg  <= request.node_id[hid_pkg::NODE_W-1];
            cnt     <= '0;
            started <= 1'b0;
            ndig    <= '0;
            rem     <= '0;
            len     <= '0;
            lead0   <= 1'b0;
            groups  <= '0;
            full    <= '0;
            parent  <= '0;
            slot    <= '0;
            if ((request.node_id == '0) || request.node_id[hid_pkg::NODE_W-1]) begin
              state <= hid_pkg::ST_LOAD;
            end else begin
              state <= hid_pkg::ST_CONV;
            end
          end
        end
        hid_pkg::ST_CONV: begin
          bcd <= {bcd_adj[hid_pkg::BCD_W-2:0], mag[hid_pkg::MAG_W-1]};
          mag <= {mag[hid_pkg::MAG_W-2:0], 1'b0};
          if (cnt == hid_pkg::CONV_LAST) begin
            cnt   <= '0;
            state <= hid_pkg::ST_WALK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        hid_pkg::ST_WALK: begin
          bcd <= {bcd[hid_pkg::BCD_W-5:0], 4'd0};
          if (take) begin
            started <= 1'b1;
            ndig    <= ndig + 1'b1;
            full    <= full_next;
            if (rem == 4'd0) begin
              // length digit: everything before it is the parent so far
              parent <= full;
              len    <= digit;
              rem    <= digit;
              groups <= groups + 1'b1;
              slot   <= '0;
            end else begin
              if (rem == len) begin
                lead0 <= (digit == 4'd0);
              end
              slot <= slot_next;
              rem  <= rem - 1'b1;
            end
          end
          if (cnt == hid_pkg::WALK_LAST) begin
            state <= hid_pkg::ST_LOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        hid_pkg::ST_LOAD: begin
          // hold until the output register is free
          if (out_free) begin
            out_vld <= 1'b1;
            if (is_root) begin
              out_ok     <= 1'b1;
              out_level  <= '0;
              out_slot   <= '0;
              out_parent <= '1;
            end else if (!is_neg && walk_ok) begin
              out_ok     <= 1'b1;
              out_level  <= {1'b0, groups};
              out_slot   <= slot;
              out_parent <= parent;
            end else begin
              out_ok     <= 1'b0;
              out_level  <= '1;
              out_slot   <= '1;
              out_parent <= '1;
            end
            state <= hid_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= hid_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = out_vld;
  assign result.id_valid    = out_ok;
  assign result.tree_level  = out_level;
  assign result.child_slot  = out_slot;
  assign result.parent_code = out_parent;

endmodule

[rtl/core/hid_check.sv]
module hid_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              id_valid,
  input logic [hid_pkg::LEVEL_W-1:0]       tree_level,
  input logic [hid_pkg::SLOT_W-1:0]        child_slot,
  input logic [hid_pkg::PARENT_W-1:0]      parent_code
);

  // a stalled result word keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(id_valid) && $stable(tree_level) &&
      $stable(child_slot) && $stable(parent_code))
    else $error("result word changed while stalled");

  // an invalid ID reports minus one in every field
  a_invalid_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid && !id_valid |-> (tree_level == '1) && (child_slot == '1) &&
      (parent_code == '1))
    else $error("invalid result not filled with minus one");

  // root carries slot zero and no parent
  a_root: assert property (@(posedge clk) disable iff (rst)
    res_valid && id_valid && (tree_level == '0) |-> (child_slot == '0) &&
      (parent_code == '1))
    else $error("root result malformed");

  // a valid level is never negative
  a_level_sign: assert property (@(posedge clk) disable iff (rst)
    res_valid && id_valid |-> !tree_level[hid_pkg::LEVEL_W-1])
    else $error("valid result with negative level");

  // one ID at a time: no acceptance straight after another
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule

bind hierarchical_id_parse hid_check u_hid_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .id_valid    (result.id_valid),
  .tree_level  (result.tree_level),
  .child_slot  (result.child_slot),
  .parent_code (result.parent_code)
);
